[hw/rtl/word_tokenizer_hash_macros.svh]
// Assertion macros shared by the word tokenizer RTL.
`ifndef WORD_TOKENIZER_HASH_MACROS_SVH
`define WORD_TOKENIZER_HASH_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define WTH_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define WTH_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hw/rtl/wth_pkg.sv]
// Shared constants, types and hash functions of the word tokenizer.
package wth_pkg;

    // Word length cap and hash bucket size.
    localparam int MAX_LEN   = 1000;
    localparam int HASH_BITS = 20;

    localparam int LEN_W    = $clog2(MAX_LEN);
    localparam int HASH_W   = 32;
    localparam int BUCKET_W = 20;
    localparam int WLEN_W   = 10;

    localparam logic [LEN_W-1:0] LEN_FULL   = LEN_W'(MAX_LEN - 1);
    localparam logic [30:0]      BUCKET_MSK = 31'((64'd1 << HASH_BITS) - 64'd1);
    localparam logic [31:0]      SEED_RST   = 32'd1159241;

    // Result queue geometry.
    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    // Control byte codes.
    localparam logic [7:0] CH_NUL   = 8'd0;
    localparam logic [7:0] CH_TAB   = 8'd9;
    localparam logic [7:0] CH_LF    = 8'd10;
    localparam logic [7:0] CH_VT    = 8'd11;
    localparam logic [7:0] CH_FF    = 8'd12;
    localparam logic [7:0] CH_CR    = 8'd13;
    localparam logic [7:0] CH_SPACE = 8'd32;

    typedef enum logic {
        IN_BYTE = 1'b0,
        IN_END  = 1'b1
    } in_kind_t;

    typedef enum logic {
        RES_WORD  = 1'b0,
        RES_BREAK = 1'b1
    } res_kind_t;

    typedef struct packed {
        res_kind_t           kind;
        logic [BUCKET_W-1:0] bucket;
        logic [WLEN_W-1:0]   length;
        logic                last;
    } res_t;

    // One step of the shift-add-xor hash; the byte is sign-extended.
    function automatic logic [HASH_W-1:0] wth_mix(input logic [HASH_W-1:0] h,
                                                  input logic [7:0] b);
        logic [HASH_W-1:0] c;
        c = {{(HASH_W-8){b[7]}}, b};
        return h ^ ((h << 5) + c + (h >> 2));
    endfunction

    function automatic logic [BUCKET_W-1:0] wth_bucket(input logic [HASH_W-1:0] h);
        logic [30:0] m;
        m = h[30:0] & BUCKET_MSK;
        return BUCKET_W'(m);
    endfunction

    function automatic logic wth_is_punct(input logic [7:0] b);
        return (b >= 8'd33 && b <= 8'd47) || (b >= 8'd58 && b <= 8'd64) ||
               (b >= 8'd91 && b <= 8'd96) || (b >= 8'd123 && b <= 8'd126);
    endfunction

endpackage

[hw/rtl/wth_res_queue.sv]
// Result queue: takes up to two results a cycle, hands out one a cycle while the receiver is ready.
module wth_res_queue import wth_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic [1:0] push_n,
    input  res_t       push0,
    input  res_t       push1,
    output logic       room,
    output logic       m_valid,
    input  logic       m_ready,
    output res_t       m_data
);

    res_t              mem [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;
    logic              pop;
    logic [QPTR_W-1:0] wr_ptr_p1;

    assign pop       = m_valid && m_ready;
    assign wr_ptr_p1 = QPTR_W'(wr_ptr_reg + 1'b1);
    assign room      = count_reg <= QCNT_W'(QDEPTH - 2);
    assign m_valid   = count_reg != '0;
    assign m_data    = mem[rd_ptr_reg];

    // Advance pointers and occupancy.
    always_comb begin
        wr_ptr_next = QPTR_W'(wr_ptr_reg + push_n);
        rd_ptr_next = pop ? QPTR_W'(rd_ptr_reg + 1'b1) : rd_ptr_reg;
        count_next  = QCNT_W'(count_reg + QCNT_W'(push_n) - QCNT_W'(pop));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the first and second result of a request.
    always_ff @(posedge aclk) begin
        if (push_n != 2'd0) begin
            mem[wr_ptr_reg] <= push0;
        end
        if (push_n == 2'd2) begin
            mem[wr_ptr_p1] <= push1;
        end
    end

endmodule

[hw/rtl/word_tokenizer_hash.sv]
// A request is registered at acceptance; once the request stage fires, its results
// are written to the result queue, which offers a second result after the first.
// Throughput: one request per cycle; the one-result-per-cycle output port limits
// requests that give two results. The request stage stalls when the result queue
// has room for fewer than two results. Reset (synchronous, active low) clears the
// word state and queue and sets the hash seed to 1159241; no clearing pass.
`include "word_tokenizer_hash_macros.svh"
module word_tokenizer_hash import wth_pkg::*; (
    input  logic                aclk,
    input  logic                aresetn,
    // Seed register write channel
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [HASH_W-1:0]   cfg_data,
    // Byte input channel
    input  logic                s_valid,
    output logic                s_ready,
    input  logic                s_kind,
    input  logic [7:0]          s_byte_value,
    // Result channel
    output logic                m_valid,
    input  logic                m_ready,
    output logic                m_result_kind,
    output logic [BUCKET_W-1:0] m_bucket,
    output logic [WLEN_W-1:0]   m_word_length,
    output logic                m_last
);

    logic [HASH_W-1:0] seed_val_reg;

    logic              in_valid_reg;
    in_kind_t          in_kind_reg;
    logic [7:0]        in_byte_reg;

    logic              in_word_reg, in_word_next;
    logic [LEN_W-1:0]  pend_len_reg, pend_len_next;
    logic [HASH_W-1:0] run_hash_reg, run_hash_next;
    logic [HASH_W-1:0] hh_reg [3];
    logic [7:0]        bh_reg [3];

    logic              proc_fire;
    logic              q_room;
    logic [1:0]        push_n;
    res_t              res0, res1, m_data;
    res_t              word_res, brk_res, punct_res;
    logic              full;
    logic              append;
    logic [7:0]        byte_low;
    logic [HASH_W-1:0] hash_base;
    logic [LEN_W-1:0]  fin_len;
    logic [HASH_W-1:0] fin_hash;

    assign cfg_ready = 1'b1;
    assign proc_fire = in_valid_reg && q_room;
    assign s_ready   = !in_valid_reg || proc_fire;

    // Hold the seed register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seed_val_reg <= SEED_RST;
        end else if (cfg_valid && cfg_ready) begin
            seed_val_reg <= cfg_data;
        end
    end

    // Register the incoming request.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_kind_reg <= in_kind_t'(s_kind);
            in_byte_reg <= s_byte_value;
        end
    end

    // Lower the byte and pick the hash start.
    always_comb begin
        byte_low  = in_byte_reg;
        if (in_byte_reg >= 8'd65 && in_byte_reg <= 8'd90) begin
            byte_low = in_byte_reg | 8'h20;
        end
        hash_base = in_word_reg ? run_hash_reg : seed_val_reg;
        full      = pend_len_reg == LEN_FULL;
    end

    // Finish the pending word, trimming a split multibyte tail of a full word.
    always_comb begin
        fin_len  = pend_len_reg;
        fin_hash = run_hash_reg;
        if (full && bh_reg[0][7]) begin
            if (bh_reg[0][7:6] == 2'b11) begin
                fin_len  = pend_len_reg - LEN_W'(1);
                fin_hash = hh_reg[0];
            end else if (bh_reg[1][7:5] == 3'b111) begin
                fin_len  = pend_len_reg - LEN_W'(2);
                fin_hash = hh_reg[1];
            end else if (bh_reg[2][7:3] == 5'b11110) begin
                fin_len  = pend_len_reg - LEN_W'(3);
                fin_hash = hh_reg[2];
            end
        end
        word_res  = '{kind: RES_WORD, bucket: wth_bucket(fin_hash),
                      length: WLEN_W'(fin_len), last: 1'b0};
        brk_res   = '{kind: RES_BREAK, bucket: '0, length: '0, last: 1'b0};
        punct_res = '{kind: RES_WORD,
                      bucket: wth_bucket(wth_mix(seed_val_reg, in_byte_reg)),
                      length: WLEN_W'(1), last: 1'b0};
    end

    // Decode the request into results and the next word state.
    always_comb begin
        push_n        = 2'd0;
        res0          = brk_res;
        res1          = brk_res;
        append        = 1'b0;
        in_word_next  = in_word_reg;
        pend_len_next = pend_len_reg;
        run_hash_next = run_hash_reg;
        if (proc_fire) begin
            if (in_kind_reg == IN_END) begin
                push_n        = 2'd1;
                res0          = in_word_reg ? word_res : brk_res;
                in_word_next  = 1'b0;
                pend_len_next = '0;
            end else begin
                case (in_byte_reg) inside
                    CH_CR: begin
                    end
                    CH_LF: begin
                        push_n        = in_word_reg ? 2'd2 : 2'd1;
                        res0          = in_word_reg ? word_res : brk_res;
                        res1          = brk_res;
                        in_word_next  = 1'b0;
                        pend_len_next = '0;
                    end
                    CH_NUL, CH_VT, CH_FF: begin
                        push_n        = 2'd1;
                        res0          = in_word_reg ? word_res : brk_res;
                        in_word_next  = 1'b0;
                        pend_len_next = '0;
                    end
                    CH_SPACE, CH_TAB: begin
                        push_n        = in_word_reg ? 2'd1 : 2'd0;
                        res0          = word_res;
                        in_word_next  = 1'b0;
                        pend_len_next = '0;
                    end
                    default: begin
                        if (!full) begin
                            if (wth_is_punct(in_byte_reg)) begin
                                push_n        = in_word_reg ? 2'd2 : 2'd1;
                                res0          = in_word_reg ? word_res : punct_res;
                                res1          = punct_res;
                                in_word_next  = 1'b0;
                                pend_len_next = '0;
                            end else begin
                                append        = 1'b1;
                                in_word_next  = 1'b1;
                                pend_len_next = LEN_W'(pend_len_reg + 1'b1);
                                run_hash_next = wth_mix(hash_base, byte_low);
                            end
                        end
                    end
                endcase
            end
        end
        res0.last = push_n == 2'd1;
        res1.last = 1'b1;
    end

    // Update the word state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_word_reg  <= 1'b0;
            pend_len_reg <= '0;
        end else begin
            in_word_reg  <= in_word_next;
            pend_len_reg <= pend_len_next;
        end
    end

    // Advance running hash and the short hash and byte histories.
    always_ff @(posedge aclk) begin
        run_hash_reg <= run_hash_next;
        if (append) begin
            hh_reg[2] <= hh_reg[1];
            hh_reg[1] <= hh_reg[0];
            hh_reg[0] <= hash_base;
            bh_reg[2] <= bh_reg[1];
            bh_reg[1] <= bh_reg[0];
            bh_reg[0] <= byte_low;
        end
    end

    wth_res_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push_n  (push_n),
        .push0   (res0),
        .push1   (res1),
        .room    (q_room),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    assign m_result_kind = m_data.kind;
    assign m_bucket      = m_data.bucket;
    assign m_word_length = m_data.length;
    assign m_last        = m_data.last;

    `WTH_ASSERT_NOW(a_idle_len_zero, !in_word_reg, pend_len_reg == '0,
        "pending length nonzero outside a word")
    `WTH_ASSERT_NOW(a_len_cap, 1'b1, pend_len_reg <= LEN_FULL,
        "pending length beyond word cap")
    `WTH_ASSERT_NOW(a_break_empty, m_valid && m_result_kind == RES_BREAK,
        m_bucket == '0 && m_word_length == '0, "line break carries word data")
    `WTH_ASSERT_NEXT(a_req_held, in_valid_reg && !proc_fire, in_valid_reg,
        "stalled request lost")

endmodule
